[hdl/jse_pkg.sv]
package jse_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned MaxRun  = 6;
  localparam int unsigned IdxW    = $clog2(MaxRun);

  localparam logic [ByteW-1:0] ChQuote  = 8'h22;
  localparam logic [ByteW-1:0] ChBslash = 8'h5C;
  localparam logic [ByteW-1:0] ChBs     = 8'h08;
  localparam logic [ByteW-1:0] ChFf     = 8'h0C;
  localparam logic [ByteW-1:0] ChLf     = 8'h0A;
  localparam logic [ByteW-1:0] ChCr     = 8'h0D;
  localparam logic [ByteW-1:0] ChTab    = 8'h09;
  localparam logic [ByteW-1:0] ChDel    = 8'h7F;
  localparam logic [ByteW-1:0] ChSpace  = 8'h20;
  localparam logic [ByteW-1:0] ChZero   = 8'h30;
  localparam logic [ByteW-1:0] ChLowA   = 8'h61;
  localparam logic [ByteW-1:0] ChLowB   = 8'h62;
  localparam logic [ByteW-1:0] ChLowF   = 8'h66;
  localparam logic [ByteW-1:0] ChLowN   = 8'h6E;
  localparam logic [ByteW-1:0] ChLowR   = 8'h72;
  localparam logic [ByteW-1:0] ChLowT   = 8'h74;
  localparam logic [ByteW-1:0] ChLowU   = 8'h75;

  // Escape class of one raw byte
  typedef enum logic [1:0] {
    KindPlain   = 2'd0,
    KindShort   = 2'd1,
    KindUnicode = 2'd2
  } jse_kind_e;

  // One escaped output byte plus its end-of-run flag
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } jse_sym_t;

  // Lowercase hex digit for a nibble
  function automatic logic [ByteW-1:0] hex_char(input logic [3:0] nib);
    logic [ByteW-1:0] ext;
    ext = {4'd0, nib};
    if (nib < 4'd10) begin
      hex_char = ChZero + ext;
    end else begin
      hex_char = ChLowA + ext - 8'd10;
    end
  endfunction

endpackage

[hdl/json_string_escaper_unit.sv]
// JSON string escaper.
// Input channel: in_valid_i / in_stall_o with in_byte_i, one raw string byte
// per transfer. Output channel: out_valid_o / out_stall_i with out_byte_o and
// run_last_o; each input byte yields a run of 1, 2 or 6 output bytes, and
// run_last_o marks the final byte of every run.
// The first output byte of a run passes from the input through the hold
// register, then the output register.
// Throughput: one output byte per cycle while out_stall_i is low. An input
// byte occupies the hold register until its whole run is out; the hold
// register is freed in the same cycle its last byte moves to the output
// register, so a new byte is taken while the previous result is still
// waiting at the output.
// Reset: clears the hold and output valid flags and the run position; no
// escape state lives across bytes.
// Stall: while a valid output is stalled, the output register holds, the run
// position stops, and in_stall_o rises once the hold register is occupied.
module json_string_escaper_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [jse_pkg::ByteW-1:0] in_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [jse_pkg::ByteW-1:0] out_byte_o,
  output logic                      run_last_o
);

  logic [jse_pkg::ByteW-1:0] byte_q;
  logic                      full_q;
  logic [jse_pkg::IdxW-1:0]  idx_q, idx_d;
  logic [jse_pkg::ByteW-1:0] out_byte_q;
  logic                      run_last_q;
  logic                      out_valid_q;

  jse_pkg::jse_sym_t sym;
  logic              out_load;
  logic              run_done;
  logic              in_fire;

  jse_decode u_decode (
    .byte_i (byte_q),
    .idx_i  (idx_q),
    .sym_o  (sym)
  );

  // Move one run byte whenever the output register is empty or being drained
  assign out_load   = full_q && (!out_valid_q || !out_stall_i);
  assign run_done   = out_load && sym.last;
  assign in_stall_o = full_q && !run_done;
  assign in_fire    = in_valid_i && !in_stall_o;

  // Advance through the run; restart at zero once the last byte moves
  assign idx_d = run_done ? '0 : (idx_q + jse_pkg::IdxW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        full_q <= 1'b1;
      end else if (run_done) begin
        full_q <= 1'b0;
      end
      if (out_load) begin
        idx_q <= idx_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: capture on transfer, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byte_q <= in_byte_i;
    end
    if (out_load) begin
      out_byte_q <= sym.data;
      run_last_q <= sym.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = run_last_q;

endmodule

[hdl/jse_decode.sv]
module jse_decode (
  input  logic [jse_pkg::ByteW-1:0] byte_i,
  input  logic [jse_pkg::IdxW-1:0]  idx_i,
  output jse_pkg::jse_sym_t         sym_o
);

  logic [jse_pkg::ByteW-1:0] letter;
  jse_pkg::jse_kind_e        kind;
  logic [jse_pkg::IdxW-1:0]  last_idx;

  always_comb begin
    letter = '0;
    unique case (byte_i)
      jse_pkg::ChQuote:  letter = jse_pkg::ChQuote;
      jse_pkg::ChBslash: letter = jse_pkg::ChBslash;
      jse_pkg::ChBs:     letter = jse_pkg::ChLowB;
      jse_pkg::ChFf:     letter = jse_pkg::ChLowF;
      jse_pkg::ChLf:     letter = jse_pkg::ChLowN;
      jse_pkg::ChCr:     letter = jse_pkg::ChLowR;
      jse_pkg::ChTab:    letter = jse_pkg::ChLowT;
      default:           letter = '0;
    endcase
  end

  always_comb begin
    if (letter != '0) begin
      kind     = jse_pkg::KindShort;
      last_idx = jse_pkg::IdxW'(1);
    end else if (byte_i < jse_pkg::ChSpace || byte_i == jse_pkg::ChDel) begin
      kind     = jse_pkg::KindUnicode;
      last_idx = jse_pkg::IdxW'(jse_pkg::MaxRun - 1);
    end else begin
      kind     = jse_pkg::KindPlain;
      last_idx = '0;
    end
  end

  // Pick the run byte at the current position
  always_comb begin
    sym_o.data = byte_i;
    case (kind)
      jse_pkg::KindShort: begin
        sym_o.data = (idx_i == '0) ? jse_pkg::ChBslash : letter;
      end
      jse_pkg::KindUnicode: begin
        case (idx_i)
          3'd0:    sym_o.data = jse_pkg::ChBslash;
          3'd1:    sym_o.data = jse_pkg::ChLowU;
          3'd2:    sym_o.data = jse_pkg::ChZero;
          3'd3:    sym_o.data = jse_pkg::ChZero;
          3'd4:    sym_o.data = jse_pkg::hex_char(byte_i[7:4]);
          default: sym_o.data = jse_pkg::hex_char(byte_i[3:0]);
        endcase
      end
      default: sym_o.data = byte_i;
    endcase
    sym_o.last = (idx_i == last_idx);
  end

endmodule

[hdl/jse_checker.sv]
module jse_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic [jse_pkg::ByteW-1:0] in_byte_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [jse_pkg::ByteW-1:0] out_byte_o,
  input logic                      run_last_o
);

  logic out_fire;
  logic prev_last_q;

  assign out_fire = out_valid_o && !out_stall_i;

  // Track whether the previous output transfer closed a run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_last_q <= 1'b1;
    end else if (out_fire) begin
      prev_last_q <= run_last_o;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) && $stable(run_last_o))
    else $error("output changed while stalled");

  a_escape_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && prev_last_q && !run_last_o |-> out_byte_o == jse_pkg::ChBslash)
    else $error("multi-byte run does not start with backslash");

  a_escape_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !prev_last_q && run_last_o |-> out_byte_o >= jse_pkg::ChQuote)
    else $error("escape run ends with an invalid byte");

  a_plain_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && prev_last_q && run_last_o |->
      out_byte_o >= jse_pkg::ChSpace && out_byte_o != jse_pkg::ChDel &&
      out_byte_o != jse_pkg::ChQuote && out_byte_o != jse_pkg::ChBslash)
    else $error("byte that needs escaping passed through");

endmodule

bind json_string_escaper_unit jse_checker u_jse_checker (.*);
